// ===== rtl/core/evs_pkg.sv =====
// Shared constants, codes and width helpers for the element-wise vector sum block.
package evs_pkg;

  localparam int MAX_LENGTH = 64;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int LEN_W      = IDX_W + 1;
  localparam int DATA_W     = 64;
  localparam int WCODE_W    = 2;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 3;

  localparam logic [ACTION_W-1:0] ACT_ACCUMULATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READOUT    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABOVE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LENGTH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

  localparam logic [WCODE_W-1:0] WC_8  = 2'd0;
  localparam logic [WCODE_W-1:0] WC_16 = 2'd1;
  localparam logic [WCODE_W-1:0] WC_32 = 2'd2;
  localparam logic [WCODE_W-1:0] WC_64 = 2'd3;

  // Sign-extend the low element-width bits of a word
  function automatic logic [DATA_W-1:0] narrow(input logic [DATA_W-1:0] x,
                                               input logic [WCODE_W-1:0] wcode);
    case (wcode)
      WC_8:    return {{56{x[7]}}, x[7:0]};
      WC_16:   return {{48{x[15]}}, x[15:0]};
      WC_32:   return {{32{x[31]}}, x[31:0]};
      default: return x;
    endcase
  endfunction

  // A sum fits the signed width when all bits from the width's sign bit up agree
  function automatic logic sum_fits(input logic [DATA_W:0] s,
                                    input logic [WCODE_W-1:0] wcode);
    case (wcode)
      WC_8:    return (&s[DATA_W:7])  | ~(|s[DATA_W:7]);
      WC_16:   return (&s[DATA_W:15]) | ~(|s[DATA_W:15]);
      WC_32:   return (&s[DATA_W:31]) | ~(|s[DATA_W:31]);
      default: return s[DATA_W] == s[DATA_W-1];
    endcase
  endfunction

endpackage

// ===== rtl/core/evs_in_if.sv =====
// Input channel: one action item per handshake.
interface evs_in_if;
  logic                          valid;
  logic                          ready;
  logic [evs_pkg::ACTION_W-1:0]  action;
  logic signed [evs_pkg::DATA_W-1:0] element_value;
  logic                          element_is_null;
  logic                          last_in_array;

  modport source (output valid, output action, output element_value,
                  output element_is_null, output last_in_array, input ready);
  modport sink   (input valid, input action, input element_value,
                  input element_is_null, input last_in_array, output ready);
endinterface

// ===== rtl/core/evs_out_if.sv =====
// Output channel: one sum or status item per handshake.
interface evs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [evs_pkg::DATA_W-1:0] sum_value;
  logic [evs_pkg::IDX_W-1:0]         position;
  logic [evs_pkg::STATUS_W-1:0]      status;
  logic                              last_result;

  modport source (output valid, output sum_value, output position,
                  output status, output last_result, input ready);
  modport sink   (input valid, input sum_value, input position,
                  input status, input last_result, output ready);
endinterface

// ===== rtl/core/evs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module evs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/elementwise_vector_sum_checked.sv =====
// Element-wise vector sum over streamed arrays with sticky overflow and length checks.
// Accumulate: an element of the first array is stored at once; a later one is held while
// its stored sum is read, then one 65-bit add and range check and write-back follow.
// Readout: each sum is read, then sent once the output is free; error or empty: one item.
// Reset (rst, synchronous): element width 64, no vector, no error; sum memory is not cleared.
module elementwise_vector_sum_checked (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [evs_pkg::WCODE_W-1:0]   cfg_wdata,
  evs_in_if.sink                        elements,
  evs_out_if.source                     results
);
  import evs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC_ADD,
    S_RO_READ,
    S_RO_LOAD,
    S_RO_ONE
  } state_t;

  state_t               state;
  logic [WCODE_W-1:0]   width_code;
  logic [LEN_W-1:0]     vector_length;
  logic [LEN_W-1:0]     element_index;
  logic                 init_flag;
  logic [STATUS_W-1:0]  sticky_error;
  logic [IDX_W-1:0]     error_position;
  logic [DATA_W-1:0]    acc_value;
  logic                 acc_last;
  logic [IDX_W-1:0]     ro_idx;

  logic                 out_valid;
  logic [DATA_W-1:0]    out_sum;
  logic [IDX_W-1:0]     out_pos;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_last;

  logic                 in_fire;
  logic                 out_free;
  logic                 out_load;
  logic [DATA_W-1:0]    elem_v;
  logic [DATA_W-1:0]    stored;
  logic [DATA_W:0]      sum65;
  logic                 fits;
  logic                 first_len_err;
  logic                 later_len_err;
  logic                 ro_last;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [DATA_W-1:0]    wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [DATA_W-1:0]    rd_data;

  assign elements.ready      = (state == S_IDLE);
  assign in_fire             = elements.valid && elements.ready;
  assign out_free            = !out_valid || results.ready;
  assign out_load            = out_free && ((state == S_RO_LOAD) || (state == S_RO_ONE));

  assign results.valid       = out_valid;
  assign results.sum_value   = out_sum;
  assign results.position    = out_pos;
  assign results.status      = out_status;
  assign results.last_result = out_last;

  assign elem_v = elements.element_is_null ? '0 :
                  narrow(elements.element_value, width_code);

  // Shared add and range check over the stored sum and the held element
  assign stored = narrow(rd_data, width_code);
  assign sum65  = {stored[DATA_W-1], stored} + {acc_value[DATA_W-1], acc_value};
  assign fits   = sum_fits(sum65, width_code);

  assign first_len_err = (element_index >= LEN_W'(MAX_LENGTH));
  assign later_len_err = (element_index >= vector_length) ||
                         (elements.last_in_array &&
                          ((element_index + LEN_W'(1)) != vector_length));
  assign ro_last = (({1'b0, ro_idx} + LEN_W'(1)) == vector_length);

  assign rd_addr = ((state == S_RO_READ) || (state == S_RO_LOAD)) ?
                   ro_idx : element_index[IDX_W-1:0];
  assign wr_addr = element_index[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_data = sum65[DATA_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_fire && (elements.action == ACT_ACCUMULATE) && (sticky_error == ST_OK) &&
            !init_flag && !first_len_err) begin
          wr_en   = 1'b1;
          wr_data = elem_v;
        end
      end
      S_ACC_ADD: begin
        wr_en = fits;
      end
      default: ;
    endcase
  end

  evs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LENGTH)
  ) u_sum_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      width_code     <= WC_64;
      vector_length  <= '0;
      element_index  <= '0;
      init_flag      <= 1'b0;
      sticky_error   <= ST_OK;
      error_position <= '0;
      ro_idx         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_code <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (elements.action)
              ACT_ACCUMULATE: begin
                if (sticky_error == ST_OK) begin
                  if (!init_flag) begin
                    if (first_len_err) begin
                      sticky_error   <= ST_LENGTH;
                      error_position <= IDX_W'(MAX_LENGTH - 1);
                    end else if (elements.last_in_array) begin
                      vector_length <= element_index + LEN_W'(1);
                      init_flag     <= 1'b1;
                      element_index <= '0;
                    end else begin
                      element_index <= element_index + LEN_W'(1);
                    end
                  end else if (later_len_err) begin
                    sticky_error   <= ST_LENGTH;
                    error_position <= first_len_err ? IDX_W'(MAX_LENGTH - 1) :
                                      element_index[IDX_W-1:0];
                  end else begin
                    // hold the element while the stored sum is read
                    acc_value <= elem_v;
                    acc_last  <= elements.last_in_array;
                    state     <= S_ACC_ADD;
                  end
                end
              end
              ACT_READOUT: begin
                ro_idx <= '0;
                if ((sticky_error != ST_OK) || !init_flag || (vector_length == '0)) begin
                  state <= S_RO_ONE;
                end else begin
                  state <= S_RO_READ;
                end
              end
              ACT_CLEAR: begin
                vector_length  <= '0;
                element_index  <= '0;
                init_flag      <= 1'b0;
                sticky_error   <= ST_OK;
                error_position <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ACC_ADD: begin
          if (fits) begin
            element_index <= acc_last ? '0 : element_index + LEN_W'(1);
          end else begin
            sticky_error   <= sum65[DATA_W] ? ST_BELOW : ST_ABOVE;
            error_position <= element_index[IDX_W-1:0];
          end
          state <= S_IDLE;
        end
        S_RO_READ: begin
          state <= S_RO_LOAD;
        end
        S_RO_LOAD: begin
          if (out_free) begin
            out_sum    <= stored;
            out_pos    <= ro_idx;
            out_status <= ST_OK;
            out_last   <= ro_last;
            if (ro_last) begin
              state <= S_IDLE;
            end else begin
              ro_idx <= ro_idx + IDX_W'(1);
              state  <= S_RO_READ;
            end
          end
        end
        S_RO_ONE: begin
          if (out_free) begin
            out_sum   <= '0;
            out_last  <= 1'b1;
            if (sticky_error != ST_OK) begin
              out_pos    <= error_position;
              out_status <= sticky_error;
            end else begin
              out_pos    <= '0;
              out_status <= ST_EMPTY;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The sum memory is never written while a readout walks it
  a_no_write_in_readout: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == S_IDLE) || (state == S_ACC_ADD)))
    else $error("sum memory written during readout");

  // An error or empty report is always a single, final item
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("non-ok status item without last flag");

  // A clear drops the vector and any error
  a_clear_effect: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (elements.action == ACT_CLEAR)) |=>
      ((sticky_error == ST_OK) && !init_flag && (vector_length == '0)))
    else $error("clear did not reset group state");

  // The vector length never exceeds the sum memory
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    vector_length <= LEN_W'(MAX_LENGTH))
    else $error("vector length beyond memory depth");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the element-wise vector sum block.
module tb;
  import evs_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0]   MAX64      = 64'h7fff_ffff_ffff_ffff;
  localparam logic [DATA_W-1:0]   MIN64      = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [DATA_W-1:0]   sum;
    logic [IDX_W-1:0]    pos;
    logic [STATUS_W-1:0] status;
    logic                last;
  } sum_item_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [WCODE_W-1:0]  cfg_wdata;

  evs_in_if  in_ch ();
  evs_out_if out_ch ();

  elementwise_vector_sum_checked uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .elements  (in_ch),
    .results   (out_ch)
  );

  // Predicted block state
  logic [DATA_W-1:0]   acc_sums [0:MAX_LENGTH-1];
  int unsigned         acc_len;
  int unsigned         acc_idx;
  bit                  acc_have_vector;
  logic [STATUS_W-1:0] acc_err;
  logic [IDX_W-1:0]    acc_err_pos;
  logic [WCODE_W-1:0]  acc_wcode;

  sum_item_t readout_due [$];
  int        fail_count;
  int        counted_items;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sign-extend the low bits of the chosen element width
  function automatic logic [DATA_W-1:0] to_width(input logic [DATA_W-1:0] x,
                                                 input logic [WCODE_W-1:0] code);
    int sh;
    sh = DATA_W - (8 << code);
    return $signed(x << sh) >>> sh;
  endfunction

  function automatic void flag_error(input logic [STATUS_W-1:0] code, input int unsigned pos);
    acc_err     = code;
    acc_err_pos = (pos >= MAX_LENGTH) ? IDX_W'(MAX_LENGTH - 1) : IDX_W'(pos);
  endfunction

  // Queue one predicted result item at the tail
  function automatic void due_item(input sum_item_t item);
    readout_due = {readout_due, item};
  endfunction

  function automatic void accumulate_element(input logic [DATA_W-1:0] val, input bit nul,
                                             input bit lst);
    logic [DATA_W-1:0]   v;
    logic [DATA_W-1:0]   a;
    logic signed [DATA_W:0] total, hi, lo;
    int                  w;
    w  = 8 << acc_wcode;
    v  = nul ? '0 : to_width(val, acc_wcode);
    hi = (65'sd1 <<< (w - 1)) - 65'sd1;
    lo = -hi - 65'sd1;
    if (acc_err != ST_OK) return;
    if (!acc_have_vector) begin
      if (acc_idx >= MAX_LENGTH) begin
        flag_error(ST_LENGTH, MAX_LENGTH - 1);
        return;
      end
      acc_sums[acc_idx] = v;
      if (lst) begin
        acc_len         = acc_idx + 1;
        acc_have_vector = 1'b1;
        acc_idx         = 0;
      end else begin
        acc_idx = acc_idx + 1;
      end
      return;
    end
    // length check takes precedence over the range check
    if (acc_idx >= acc_len || (lst && acc_idx + 1 != acc_len)) begin
      flag_error(ST_LENGTH, acc_idx);
      return;
    end
    a = to_width(acc_sums[acc_idx], acc_wcode);
    acc_sums[acc_idx] = a;
    total = $signed({a[DATA_W-1], a}) + $signed({v[DATA_W-1], v});
    if (total > hi) begin
      flag_error(ST_ABOVE, acc_idx);
    end else if (total < lo) begin
      flag_error(ST_BELOW, acc_idx);
    end else begin
      acc_sums[acc_idx] = to_width(total[DATA_W-1:0], acc_wcode);
      acc_idx = lst ? 0 : acc_idx + 1;
    end
  endfunction

  function automatic void apply_action(input logic [ACTION_W-1:0] act,
                                       input logic [DATA_W-1:0] val, input bit nul,
                                       input bit lst);
    case (act)
      ACT_ACCUMULATE: accumulate_element(val, nul, lst);
      ACT_CLEAR: begin
        acc_len         = 0;
        acc_idx         = 0;
        acc_have_vector = 1'b0;
        acc_err         = ST_OK;
        acc_err_pos     = '0;
      end
      ACT_READOUT: begin
        if (acc_err != ST_OK) begin
          due_item('{sum: '0, pos: acc_err_pos, status: acc_err, last: 1'b1});
        end else if (!acc_have_vector || acc_len == 0) begin
          due_item('{sum: '0, pos: '0, status: ST_EMPTY, last: 1'b1});
        end else begin
          for (int i = 0; i < acc_len; i++)
            due_item('{sum: to_width(acc_sums[i], acc_wcode), pos: IDX_W'(i),
                       status: ST_OK, last: (i + 1 == acc_len)});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_element();
    logic [DATA_W-1:0] base, garbage, mask;
    longint            small_val;
    int                w;
    w         = 8 << acc_wcode;
    garbage   = {$urandom, $urandom};
    small_val = longint'($urandom_range(0, 40)) - 20;
    case ($urandom_range(0, 9))
      0:       base = (64'd1 << (w - 1)) - 64'd1;
      1:       base = ~((64'd1 << (w - 1)) - 64'd1);
      2, 3:    base = garbage;
      default: base = small_val;
    endcase
    // fill the bits above the width with noise now and then
    if (w < DATA_W && $urandom_range(0, 1) == 1) begin
      mask = (64'd1 << w) - 64'd1;
      base = (base & mask) | ({$urandom, $urandom} & ~mask);
    end
    return base;
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val,
                           input bit nul, input bit lst);
    @(negedge clk);
    in_ch.valid           = 1'b1;
    in_ch.action          = act;
    in_ch.element_value   = val;
    in_ch.element_is_null = nul;
    in_ch.last_in_array   = lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (!(act == ACT_UNUSED || (act == ACT_ACCUMULATE && acc_err != ST_OK)))
      counted_items++;
    apply_action(act, val, nul, lst);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 4)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic add_element(input logic [DATA_W-1:0] val, input bit lst);
    send_item(ACT_ACCUMULATE, val, 1'b0, lst);
  endtask

  task automatic request_readout();
    send_item(ACT_READOUT, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic clear_group();
    send_item(ACT_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_array(input int count, input int last_at);
    for (int i = 0; i < count; i++)
      send_item(ACT_ACCUMULATE, pick_element(), $urandom_range(0, 9) == 0, i == last_at);
  endtask

  // Hold off until every readout item has come back and the block has gone quiet
  task automatic settle_block();
    if (in_ch.valid) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    while (readout_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_width(input logic [WCODE_W-1:0] code);
    settle_block();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = code;
    @(negedge clk);
    cfg_we    = 1'b0;
    acc_wcode = code;
  endtask

  task automatic test_empty_after_reset();
    request_readout();
    send_item(ACT_UNUSED, {$urandom, $urandom}, 1'b1, 1'b1);
    request_readout();
  endtask

  task automatic test_overflow_64();
    add_element(MAX64, 1'b0);
    add_element(MIN64, 1'b0);
    send_item(ACT_ACCUMULATE, {$urandom, $urandom}, 1'b1, 1'b0);
    add_element(64'd5, 1'b1);
    request_readout();
    add_element(64'd1, 1'b0);
    request_readout();
    add_element(64'd1, 1'b1);
    clear_group();
    request_readout();
    add_element(MIN64, 1'b1);
    add_element(64'hffff_ffff_ffff_ffff, 1'b1);
    request_readout();
    clear_group();
  endtask

  task automatic test_length_checks();
    set_width(WC_8);
    add_element(64'h5a5a_5a5a_5a5a_5a80, 1'b0);
    add_element(64'h0000_0000_0000_007f, 1'b0);
    add_element(64'd3, 1'b1);
    add_element(64'hffff_ffff_ffff_ffff, 1'b0);
    request_readout();
    clear_group();
    add_element(64'd1, 1'b0);
    add_element(64'd2, 1'b1);
    add_element(64'd1, 1'b1);
    request_readout();
    clear_group();
    add_element(64'd10, 1'b0);
    add_element(64'd20, 1'b1);
    add_element(64'd5, 1'b0);
    request_readout();
    add_element(64'd7, 1'b0);
    add_element(64'd9, 1'b1);
    request_readout();
    clear_group();
  endtask

  task automatic test_width_change();
    set_width(WC_64);
    add_element(64'h0123_4567_89ab_cdef, 1'b0);
    add_element(64'hffff_ffff_ffff_ff80, 1'b1);
    request_readout();
    set_width(WC_8);
    request_readout();
    set_width(WC_16);
    add_element(64'd1, 1'b0);
    add_element(64'd1, 1'b1);
    request_readout();
    set_width(WC_32);
    request_readout();
  endtask

  task automatic test_full_length();
    clear_group();
    send_array(MAX_LENGTH, MAX_LENGTH - 1);
    request_readout();
    clear_group();
    send_array(MAX_LENGTH + 1, -1);
    request_readout();
    clear_group();
  endtask

  task automatic run_group(input bit start_clean);
    int len, arrays, cut;
    if (start_clean) clear_group();
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAX_LENGTH) : $urandom_range(1, 8);
    send_array(len, len - 1);
    arrays = $urandom_range(1, 5);
    for (int k = 0; k < arrays; k++) begin
      case ($urandom_range(0, 19))
        0: begin
          // last mark too early, or too late for a one-element vector
          if (len > 1) begin
            cut = $urandom_range(0, len - 2);
            send_array(cut + 1, cut);
          end else begin
            send_array(2, 1);
          end
        end
        1: send_array(len + 1, len);
        2: begin
          send_item(ACT_UNUSED, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          send_array(len, len - 1);
        end
        3, 4: begin
          cut = $urandom_range(0, len - 1);
          send_array(cut, -1);
          request_readout();
          send_array(len - cut, len - cut - 1);
        end
        default: send_array(len, len - 1);
      endcase
    end
    request_readout();
  endtask

  task automatic test_random_traffic();
    logic [WCODE_W-1:0] codes [4];
    int                 phase;
    codes = '{WC_8, WC_16, WC_32, WC_64};
    phase = 0;
    while (counted_items < 150 || phase < 2) begin
      set_width((phase < 4) ? codes[phase] : codes[$urandom_range(0, 3)]);
      // keep the stored sums across a width change now and then
      run_group($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 1) == 1) run_group(1'b1);
      phase++;
    end
  endtask

  initial begin : receiver_stalls
    int stall_pct;
    int hold;
    out_ch.ready = 1'b0;
    stall_pct    = 0;
    hold         = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 60;
          default: stall_pct = 85;
        endcase
        hold = $urandom_range(10, 60);
      end
      hold--;
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    sum_item_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (readout_due.size() == 0) begin
        $display("%0t: result with none expected: sum %h position %0d status %0d last %0b",
                 $time, out_ch.sum_value, out_ch.position, out_ch.status, out_ch.last_result);
        fail_count++;
      end else begin
        want = readout_due.pop_front();
        if (out_ch.sum_value !== want.sum) begin
          $display("%0t: sum_value expected %h actual %h", $time, want.sum, out_ch.sum_value);
          fail_count++;
        end
        if (out_ch.position !== want.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, want.pos, out_ch.position);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.last_result !== want.last) begin
          $display("%0t: last_result expected %0b actual %0b", $time, want.last,
                   out_ch.last_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = WC_64;
    in_ch.valid           = 1'b0;
    in_ch.action          = ACT_ACCUMULATE;
    in_ch.element_value   = '0;
    in_ch.element_is_null = 1'b0;
    in_ch.last_in_array   = 1'b0;
    acc_len               = 0;
    acc_idx               = 0;
    acc_have_vector       = 1'b0;
    acc_err               = ST_OK;
    acc_err_pos           = '0;
    acc_wcode             = WC_64;
    fail_count            = 0;
    counted_items         = 0;
    burst_left            = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_empty_after_reset();
    test_overflow_64();
    test_length_checks();
    test_width_change();
    test_full_length();
    test_random_traffic();

    settle_block();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
